// File: src/tdpt_pkg.sv
// Shared types for the trial-division prime test.
// No dependencies; compiled first.
package tdpt_pkg;

  // One-hot sequencer states of the top level
  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StDivide = 3'b010,
    StEmit   = 3'b100
  } state_e;

endpackage

// File: src/tdpt_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by trial_division_prime_test.
module tdpt_divider #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(Width);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [Width:0]   shifted;
  logic [Width:0]   trial;

  // shift next dividend bit into the partial remainder and try a subtract
  assign shifted = {rem_q, quo_q[Width-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(Width - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[Width]) begin
        // subtract would go negative: restore
        rem_d = shifted[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b0};
      end else begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: src/trial_division_prime_test.sv
// Trial-division prime test: sequencer, result register and assertions.
// Depends on tdpt_pkg (state type) and tdpt_divider (shared divider).
//
// Usage:
//   Input channel (number_i, in_valid_i/in_ready_o) takes one signed value
//   per beat; output channel (prime_flag_o, out_valid_o/out_ready_i) returns
//   one flag per beat, 1 when the value is prime.
//   Negative values, zero and one are answered without any division:
//   the sequencer goes from accept straight to the emit state.
//   Otherwise divisors d = 2, 3, ... are tried on one shared restoring
//   divider. Each trial yields v / d and v % d together; the loop stops
//   when d > v / d (prime) or v % d == 0. A value takes T trials,
//   T <= floor(sqrt(v)).
//   The block takes one value at a time; in_ready_o is high only while the
//   sequencer is idle. A finished flag sits in the output register, so a new
//   value can be accepted while the previous flag waits. If the receiver
//   stalls with that register full, the next flag waits in the sequencer.
//   Reset clears the sequencer and drops any pending result.
module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          prime_flag_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);

  localparam int unsigned W = VALUE_WIDTH;

  tdpt_pkg::state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         prime_q, prime_d;
  logic         res_q, res_d;
  logic [W-1:0] v_q, v_d;
  logic [W-1:0] d_q, d_d;

  logic         accept;
  logic         trivial;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;

  assign in_ready_o = (state_q == tdpt_pkg::StIdle);
  assign accept     = in_valid_i & in_ready_o;

  // negative, zero or one: not prime, no division needed
  assign trivial = number_i[W-1] || ($unsigned(number_i) <= W'(1));

  // first trial divides the incoming value by 2, later ones use stored value
  assign div_dividend = (state_q == tdpt_pkg::StIdle) ? $unsigned(number_i) : v_q;
  assign div_divisor  = (state_q == tdpt_pkg::StIdle) ? W'(2) : d_q + W'(1);

  tdpt_divider #(
    .Width (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    d_d         = d_q;
    res_d       = res_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    div_start   = 1'b0;
    unique case (state_q)
      tdpt_pkg::StIdle: begin
        if (accept) begin
          v_d = $unsigned(number_i);
          d_d = W'(2);
          if (trivial) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::StEmit;
          end else begin
            div_start = 1'b1;
            state_d   = tdpt_pkg::StDivide;
          end
        end
      end
      tdpt_pkg::StDivide: begin
        if (div_done) begin
          priority if (d_q > div_quo) begin
            // d*d > v: no divisor left
            res_d   = 1'b1;
            state_d = tdpt_pkg::StEmit;
          end else if (div_rem == '0) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::StEmit;
          end else begin
            d_d       = d_q + W'(1);
            div_start = 1'b1;
          end
        end
      end
      tdpt_pkg::StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          prime_d     = res_q;
          out_valid_d = 1'b1;
          state_d     = tdpt_pkg::StIdle;
        end
      end
      default: state_d = tdpt_pkg::StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    d_q     <= d_d;
    res_q   <= res_d;
    prime_q <= prime_d;
  end

  assign out_valid_o  = out_valid_q;
  assign prime_flag_o = prime_q;

  // divider only reports while a trial loop is running
  a_done_in_divide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tdpt_pkg::StDivide))
    else $error("divider done outside divide state");

  // trial divisor stays within [2, v] during the loop
  a_divisor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdpt_pkg::StDivide) |-> (d_q >= W'(2)) && (d_q <= v_q))
    else $error("trial divisor out of range");

  // a prime verdict only for values of two or more
  a_prime_ge_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdpt_pkg::StEmit) && res_q |-> (v_q >= W'(2)) && !v_q[W-1])
    else $error("prime verdict on value below two");

  // a pending verdict reaches the output register once it is free
  a_emit_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdpt_pkg::StEmit) && !out_valid_q
      |=> out_valid_q && (state_q == tdpt_pkg::StIdle))
    else $error("verdict not moved to free output register");

endmodule
